@@ design/s2c_pkg.sv @@
package s2c_pkg;

   // field widths of the transaction ports
   localparam int IN_W = 16;
   localparam int ANGLE_BITS = 16;
   localparam int RADIUS_BITS = 16;
   localparam int OUT_W = RADIUS_BITS + 1;

   // CORDIC datapath: Q2.30 values, angles as 2^-32 of a full turn
   localparam int CORDIC_STEPS = 16;
   localparam int PHASE_W = 32;
   localparam int CORDIC_W = 32;
   localparam int CORDIC_GAIN = 652032874;
   localparam logic [PHASE_W-1:0] OCTANT_BIAS = PHASE_W'(1) << (PHASE_W - 3);

   // trig outputs, signed Q1.15
   localparam int TRIG_W = 16;
   localparam int TRIG_MAX = 32767;
   localparam int Q15_SHIFT = TRIG_W - 1;
   localparam int Q_W = CORDIC_W + 1 - Q15_SHIFT;
   localparam logic [CORDIC_W:0] ROUND_Q15 = (CORDIC_W + 1)'(1) << (Q15_SHIFT - 1);

   // pipeline layout: fold, CORDIC steps, convert, then product / abs / scale / round
   localparam int TRIG_STAGES = CORDIC_STEPS + 2;
   localparam int ST_PROD = TRIG_STAGES;
   localparam int ST_ABS = TRIG_STAGES + 1;
   localparam int ST_MUL = TRIG_STAGES + 2;
   localparam int ST_OUT = TRIG_STAGES + 3;
   localparam int PIPE_DEPTH = TRIG_STAGES + 4;

   // product and scaling widths
   localparam int PROD_W = 2 * TRIG_W - 1;
   localparam int MAG_W = 2 * (TRIG_W - 1);
   localparam int ZMAG_W = TRIG_W - 1;
   localparam int SCALE_W = MAG_W + RADIUS_BITS;
   localparam int ZSCALE_W = ZMAG_W + RADIUS_BITS;
   localparam logic [SCALE_W:0] ROUND_XY = (SCALE_W + 1)'(1) << (MAG_W - 1);
   localparam logic [ZSCALE_W:0] ROUND_Z = (ZSCALE_W + 1)'(1) << (ZMAG_W - 1);

   // atan(2^-i) in 2^-32 of a full turn
   localparam logic [CORDIC_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861
   };

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_1,
      QUAD_2,
      QUAD_3
   } quad_type;

   // round Q2.30 to Q1.15, ties upward, clamp to +/-TRIG_MAX
   function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
      logic [CORDIC_W:0] sum;
      logic signed [Q_W-1:0] q;
      logic signed [TRIG_W-1:0] r;
      sum = {v[CORDIC_W-1], v} + ROUND_Q15;
      q = $signed(sum[CORDIC_W:Q15_SHIFT]);
      if (q > $signed(Q_W'(TRIG_MAX))) begin
         r = TRIG_W'(TRIG_MAX);
      end else if (q < -$signed(Q_W'(TRIG_MAX))) begin
         r = -$signed(TRIG_W'(TRIG_MAX));
      end else begin
         r = q[TRIG_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ design/spherical_to_cartesian.sv @@
// Depth: 22 register stages from the stage that captures an accepted request to rsp_valid.
// Throughput: one transaction per cycle while the skid entry is empty; the pipe holds
// while it is full. Depth is set by the 16 CORDIC rotation stages per angle, plus fold,
// Q1.15 conversion, product, magnitude, scale and round stages.
// A one-entry skid register behind the output stage takes a result the consumer refuses.
// Reset (synchronous) clears the stage valid bits and the skid entry; datapath
// registers are not reset.
module spherical_to_cartesian (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [s2c_pkg::IN_W-1:0]           req_azimuth,
   input  logic [s2c_pkg::IN_W-1:0]           req_polar_angle,
   input  logic [s2c_pkg::IN_W-1:0]           req_radius,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [s2c_pkg::OUT_W-1:0]   rsp_x_coord,
   output logic signed [s2c_pkg::OUT_W-1:0]   rsp_y_coord,
   output logic signed [s2c_pkg::OUT_W-1:0]   rsp_z_coord
);
   import s2c_pkg::*;

   logic advance;
   logic skid_load;

   logic v_in [0:PIPE_DEPTH-1];
   logic v_ff [0:PIPE_DEPTH-1];
   logic skid_in;
   logic skid_ff;

   logic [RADIUS_BITS-1:0] rad_in [0:ST_ABS];
   logic [RADIUS_BITS-1:0] rad_ff [0:ST_ABS];

   logic signed [TRIG_W-1:0] az_cos;
   logic signed [TRIG_W-1:0] az_sin;
   logic signed [TRIG_W-1:0] po_cos;
   logic signed [TRIG_W-1:0] po_sin;

   // product stage
   logic signed [2*TRIG_W-1:0] prod_x_full;
   logic signed [2*TRIG_W-1:0] prod_y_full;
   logic signed [PROD_W-1:0]   px_ff;
   logic signed [PROD_W-1:0]   py_ff;
   logic signed [TRIG_W-1:0]   pz_ff;

   // magnitude stage
   logic [PROD_W-1:0] abs_x;
   logic [PROD_W-1:0] abs_y;
   logic [TRIG_W-1:0] abs_z;
   logic [MAG_W-1:0]  mx_ff;
   logic [MAG_W-1:0]  my_ff;
   logic [ZMAG_W-1:0] mz_ff;
   logic [2:0]        neg_abs_ff;

   // scale stage
   logic [SCALE_W-1:0]  sx_in;
   logic [SCALE_W-1:0]  sy_in;
   logic [ZSCALE_W-1:0] sz_in;
   logic [SCALE_W-1:0]  sx_ff;
   logic [SCALE_W-1:0]  sy_ff;
   logic [ZSCALE_W-1:0] sz_ff;
   logic [2:0]          neg_mul_ff;

   // round stage
   logic [SCALE_W:0]  rnd_x;
   logic [SCALE_W:0]  rnd_y;
   logic [ZSCALE_W:0] rnd_z;
   logic [OUT_W-1:0]  qx;
   logic [OUT_W-1:0]  qy;
   logic [OUT_W-1:0]  qz;
   logic signed [OUT_W-1:0] out_x_in;
   logic signed [OUT_W-1:0] out_y_in;
   logic signed [OUT_W-1:0] out_z_in;
   logic signed [OUT_W-1:0] out_x_ff;
   logic signed [OUT_W-1:0] out_y_ff;
   logic signed [OUT_W-1:0] out_z_ff;
   logic signed [OUT_W-1:0] skid_x_ff;
   logic signed [OUT_W-1:0] skid_y_ff;
   logic signed [OUT_W-1:0] skid_z_ff;

   // the pipe moves whenever the skid entry is free
   assign advance = !skid_ff;
   assign req_ready = advance;
   assign skid_load = !skid_ff && v_ff[ST_OUT] && !rsp_ready;

   always_comb begin
      v_in[0] = req_valid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         v_in[k] = v_ff[k-1];
      end
      skid_in = skid_ff ? !rsp_ready : skid_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            v_ff[k] <= 1'b0;
         end
         skid_ff <= 1'b0;
      end else begin
         if (advance) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
               v_ff[k] <= v_in[k];
            end
         end
         skid_ff <= skid_in;
      end
   end

   always_comb begin
      rad_in[0] = req_radius[RADIUS_BITS-1:0];
      for (int k = 1; k <= ST_ABS; k++) begin
         rad_in[k] = rad_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= ST_ABS; k++) begin
            rad_ff[k] <= rad_in[k];
         end
      end
   end

   s2c_sincos u_azimuth (
      .clock   (clock),
      .advance (advance),
      .angle   (req_azimuth[ANGLE_BITS-1:0]),
      .cos_q15 (az_cos),
      .sin_q15 (az_sin)
   );

   s2c_sincos u_polar (
      .clock   (clock),
      .advance (advance),
      .angle   (req_polar_angle[ANGLE_BITS-1:0]),
      .cos_q15 (po_cos),
      .sin_q15 (po_sin)
   );

   assign prod_x_full = po_sin * az_cos;
   assign prod_y_full = po_sin * az_sin;

   assign abs_x = px_ff[PROD_W-1] ? -px_ff : px_ff;
   assign abs_y = py_ff[PROD_W-1] ? -py_ff : py_ff;
   assign abs_z = pz_ff[TRIG_W-1] ? -pz_ff : pz_ff;

   assign sx_in = mx_ff * rad_ff[ST_ABS];
   assign sy_in = my_ff * rad_ff[ST_ABS];
   assign sz_in = mz_ff * rad_ff[ST_ABS];

   // round half away from zero on the magnitude, then restore the sign
   assign rnd_x = {1'b0, sx_ff} + ROUND_XY;
   assign rnd_y = {1'b0, sy_ff} + ROUND_XY;
   assign rnd_z = {1'b0, sz_ff} + ROUND_Z;
   assign qx = rnd_x[SCALE_W:MAG_W];
   assign qy = rnd_y[SCALE_W:MAG_W];
   assign qz = rnd_z[ZSCALE_W:ZMAG_W];
   assign out_x_in = neg_mul_ff[0] ? $signed(OUT_W'(0) - qx) : $signed(qx);
   assign out_y_in = neg_mul_ff[1] ? $signed(OUT_W'(0) - qy) : $signed(qy);
   assign out_z_in = neg_mul_ff[2] ? $signed(OUT_W'(0) - qz) : $signed(qz);

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= prod_x_full[PROD_W-1:0];
         py_ff <= prod_y_full[PROD_W-1:0];
         pz_ff <= po_cos;
         mx_ff <= abs_x[MAG_W-1:0];
         my_ff <= abs_y[MAG_W-1:0];
         mz_ff <= abs_z[ZMAG_W-1:0];
         neg_abs_ff <= {pz_ff[TRIG_W-1], py_ff[PROD_W-1], px_ff[PROD_W-1]};
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         sz_ff <= sz_in;
         neg_mul_ff <= neg_abs_ff;
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= out_z_in;
      end
      if (skid_load) begin
         skid_x_ff <= out_x_ff;
         skid_y_ff <= out_y_ff;
         skid_z_ff <= out_z_ff;
      end
   end

   assign rsp_valid = skid_ff || v_ff[ST_OUT];
   assign rsp_x_coord = skid_ff ? skid_x_ff : out_x_ff;
   assign rsp_y_coord = skid_ff ? skid_y_ff : out_y_ff;
   assign rsp_z_coord = skid_ff ? skid_z_ff : out_z_ff;

   // an accepted transaction occupies the first stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v_ff[0])
      else $error("accepted transaction not captured");

   // a refused result is parked in the skid entry
   a_refused_parks: assert property (@(posedge clock) disable iff (reset)
      !skid_ff && v_ff[ST_OUT] && !rsp_ready |=> skid_ff)
      else $error("refused result lost");

   // the skid entry drains once taken
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_ff && rsp_ready |=> !skid_ff)
      else $error("skid entry not released");

   // |result| never exceeds the radius, so the most negative code cannot occur
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_x_coord != {1'b1, {(OUT_W - 1){1'b0}}}
                 && rsp_y_coord != {1'b1, {(OUT_W - 1){1'b0}}}
                 && rsp_z_coord != {1'b1, {(OUT_W - 1){1'b0}}})
      else $error("coordinate out of range");

endmodule

@@ design/s2c_sincos.sv @@
module s2c_sincos (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic [s2c_pkg::ANGLE_BITS-1:0]       angle,
   output logic signed [s2c_pkg::TRIG_W-1:0]    cos_q15,
   output logic signed [s2c_pkg::TRIG_W-1:0]    sin_q15
);
   import s2c_pkg::*;

   logic [PHASE_W-1:0] phase;
   logic [PHASE_W-1:0] phase_bias;
   logic [PHASE_W-1:0] fold_rem;

   logic signed [CORDIC_W-1:0] x_in [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_in [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] z_in [0:CORDIC_STEPS];
   quad_type                   quad_in [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [CORDIC_W-1:0] z_ff [0:CORDIC_STEPS];
   quad_type                   quad_ff [0:CORDIC_STEPS];

   logic signed [TRIG_W-1:0] c_raw;
   logic signed [TRIG_W-1:0] s_raw;
   logic signed [TRIG_W-1:0] cos_in;
   logic signed [TRIG_W-1:0] sin_in;
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] sin_ff;

   // fold into the quarter turn centred on zero
   assign phase = {angle, {(PHASE_W - ANGLE_BITS){1'b0}}};
   assign phase_bias = phase + OCTANT_BIAS;
   assign fold_rem = phase - {phase_bias[PHASE_W-1 -: 2], {(PHASE_W - 2){1'b0}}};

   assign x_in[0] = CORDIC_W'(CORDIC_GAIN);
   assign y_in[0] = '0;
   assign z_in[0] = $signed(fold_rem);
   assign quad_in[0] = quad_type'(phase_bias[PHASE_W-1 -: 2]);

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CORDIC_W-1:0] xs;
      logic signed [CORDIC_W-1:0] ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      always_comb begin
         if (!z_ff[i][CORDIC_W-1]) begin
            x_in[i+1] = x_ff[i] - ys;
            y_in[i+1] = y_ff[i] + xs;
            z_in[i+1] = z_ff[i] - $signed(ATAN_TURN[i]);
         end else begin
            x_in[i+1] = x_ff[i] + ys;
            y_in[i+1] = y_ff[i] - xs;
            z_in[i+1] = z_ff[i] + $signed(ATAN_TURN[i]);
         end
         quad_in[i+1] = quad_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
            quad_ff[k] <= quad_in[k];
         end
      end
   end

   assign c_raw = to_q15(x_ff[CORDIC_STEPS]);
   assign s_raw = to_q15(y_ff[CORDIC_STEPS]);

   // undo the quadrant fold
   always_comb begin
      case (quad_ff[CORDIC_STEPS])
         QUAD_0: begin
            cos_in = c_raw;
            sin_in = s_raw;
         end
         QUAD_1: begin
            cos_in = -s_raw;
            sin_in = c_raw;
         end
         QUAD_2: begin
            cos_in = -c_raw;
            sin_in = -s_raw;
         end
         default: begin
            cos_in = s_raw;
            sin_in = -c_raw;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q15 = cos_ff;
   assign sin_q15 = sin_ff;

endmodule

@@ bench/spherical_to_cartesian_tb.sv @@
module spherical_to_cartesian_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import s2c_pkg::*;

   localparam int CLK_HALF = 5;
   localparam int DRAIN_LIMIT = 4000;
   localparam int SETTLE_CYCLES = PIPE_DEPTH + 8;
   localparam int RANDOM_POINTS = 480;
   localparam int STREAM_POINTS = 120;
   localparam int ROT_STEPS = 16;
   localparam longint ROT_GAIN = 652032874;
   localparam longint Q15_LIMIT = 32767;

   // atan(2^-i) in 2^-32 of a full turn
   localparam longint ROT_ATAN [ROT_STEPS] = '{
      536870912, 316933406, 167458907, 85004756,
      42667331,  21354465,  10679838,  5340245,
      2670163,   1335087,   667544,    333772,
      166886,    83443,     41722,     20861
   };

   typedef struct {
      logic [IN_W-1:0] azimuth;
      logic [IN_W-1:0] polar;
      logic [IN_W-1:0] radius;
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic signed [OUT_W-1:0] z;
   } cart_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [IN_W-1:0] req_azimuth = '0;
   logic [IN_W-1:0] req_polar_angle = '0;
   logic [IN_W-1:0] req_radius = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_x_coord;
   logic signed [OUT_W-1:0] rsp_y_coord;
   logic signed [OUT_W-1:0] rsp_z_coord;

   cart_point_type pending_points[$];
   cart_point_type head_point;
   int unsigned error_count = 0;
   int unsigned sent_count = 0;
   int unsigned checked_count = 0;
   int unsigned zero_radius_count = 0;
   int unsigned stall_len;
   bit req_idle_on = 1'b1;
   bit rsp_stall_on = 1'b1;

   spherical_to_cartesian DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_azimuth     (req_azimuth),
      .req_polar_angle (req_polar_angle),
      .req_radius      (req_radius),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_coord     (rsp_x_coord),
      .rsp_y_coord     (rsp_y_coord),
      .rsp_z_coord     (rsp_z_coord)
   );

   always #CLK_HALF clock = ~clock;

   // Q2.30 to Q1.15: round half up, then clamp symmetrically
   function automatic longint q15_round(input longint v);
      longint t;
      t = (v + 16384) >>> 15;
      if (t > Q15_LIMIT) t = Q15_LIMIT;
      if (t < -Q15_LIMIT) t = -Q15_LIMIT;
      return t;
   endfunction

   function automatic void turn_sincos(input logic [ANGLE_BITS-1:0] angle,
                                       output longint cos_q15, output longint sin_q15);
      logic [31:0] phase;
      logic [1:0] quad;
      logic [31:0] rem;
      longint xv, yv, zv, xs, ys, c, s;
      int i;
      phase = 32'(angle) << (32 - ANGLE_BITS);
      quad = 2'((phase + 32'h2000_0000) >> 30);
      rem = phase - {quad, 30'd0};
      zv = longint'($signed(rem));
      xv = ROT_GAIN;
      yv = 0;
      for (i = 0; i < ROT_STEPS; i++) begin
         xs = xv >>> i;
         ys = yv >>> i;
         if (zv >= 0) begin
            xv -= ys;
            yv += xs;
            zv -= ROT_ATAN[i];
         end else begin
            xv += ys;
            yv -= xs;
            zv += ROT_ATAN[i];
         end
      end
      c = q15_round(xv);
      s = q15_round(yv);
      case (quad_type'(quad))
         QUAD_0: begin cos_q15 = c;  sin_q15 = s;  end
         QUAD_1: begin cos_q15 = -s; sin_q15 = c;  end
         QUAD_2: begin cos_q15 = -c; sin_q15 = -s; end
         default: begin cos_q15 = s; sin_q15 = -c; end
      endcase
   endfunction

   // r * p / 2^shift, rounded to nearest with ties away from zero
   function automatic logic signed [OUT_W-1:0] scale_by_radius(input longint r, input longint p,
                                                              input int shift);
      longint mag, q;
      mag = (p < 0 ? -p : p) * r;
      q = (mag + (longint'(1) <<< (shift - 1))) >>> shift;
      if (p < 0) q = -q;
      return OUT_W'(q);
   endfunction

   function automatic cart_point_type convert_point(input logic [IN_W-1:0] az,
                                                    input logic [IN_W-1:0] pol,
                                                    input logic [IN_W-1:0] rad);
      cart_point_type pt;
      longint cph, sph, cth, sth, r;
      turn_sincos(az[ANGLE_BITS-1:0], cph, sph);
      turn_sincos(pol[ANGLE_BITS-1:0], cth, sth);
      r = longint'(rad[RADIUS_BITS-1:0]);
      pt.azimuth = az;
      pt.polar = pol;
      pt.radius = rad;
      pt.x = scale_by_radius(r, sth * cph, 30);
      pt.y = scale_by_radius(r, sth * sph, 30);
      pt.z = scale_by_radius(r, cth, 15);
      return pt;
   endfunction

   // consumer side: random stall bursts while enabled
   always begin
      @(posedge clock);
      if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
         stall_len = $urandom_range(1, 15);
         rsp_ready <= 1'b0;
         repeat (stall_len) @(posedge clock);
      end
      rsp_ready <= 1'b1;
   end

   task automatic check_coord(input string name, input logic signed [OUT_W-1:0] expected,
                              input logic signed [OUT_W-1:0] actual, input cart_point_type pt);
      if (actual !== expected) begin
         $display("%0t: %s mismatch (az=%0d pol=%0d r=%0d): expected %0d, actual %0d",
                  $time, name, pt.azimuth, pt.polar, pt.radius, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual x=%0d y=%0d z=%0d",
                     $time, rsp_x_coord, rsp_y_coord, rsp_z_coord);
            error_count++;
         end else begin
            head_point = pending_points.pop_front();
            check_coord("x_coord", head_point.x, rsp_x_coord, head_point);
            check_coord("y_coord", head_point.y, rsp_y_coord, head_point);
            check_coord("z_coord", head_point.z, rsp_z_coord, head_point);
            checked_count++;
         end
      end
   end

   // called just after a rising edge; returns on the edge that accepts the transaction
   task automatic send_point(input logic [IN_W-1:0] az, input logic [IN_W-1:0] pol,
                             input logic [IN_W-1:0] rad);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_azimuth <= az;
      req_polar_angle <= pol;
      req_radius <= rad;
      do @(posedge clock); while (!req_ready);
      pending_points.push_back(convert_point(az, pol, rad));
      sent_count++;
      if (rad[RADIUS_BITS-1:0] == 0) zero_radius_count++;
   endtask

   function automatic logic [IN_W-1:0] pick_angle();
      // a third of angles land within a few LSBs of an octant seam
      if ($urandom_range(0, 2) == 0)
         return IN_W'($urandom_range(0, 7) * 8192 + $urandom_range(0, 8) - 4);
      return IN_W'($urandom);
   endfunction

   function automatic logic [IN_W-1:0] pick_radius();
      case ($urandom_range(0, 4))
         0: return IN_W'($urandom_range(0, 15));
         1: return IN_W'(65535 - $urandom_range(0, 15));
         default: return IN_W'($urandom);
      endcase
   endfunction

   task automatic test_directed_points();
      logic [IN_W-1:0] pts [20][3] = '{
         '{16'd0,     16'd0,     16'd0},
         '{16'h1234,  16'h4321,  16'd0},
         '{16'd0,     16'd0,     16'd65535},
         '{16'd0,     16'd16384, 16'd65535},
         '{16'd16384, 16'd16384, 16'd65535},
         '{16'd32768, 16'd16384, 16'd65535},
         '{16'd49152, 16'd16384, 16'd65535},
         '{16'd0,     16'd32768, 16'd65535},
         '{16'd0,     16'd49152, 16'd65535},
         '{16'd8192,  16'd8192,  16'd65535},
         '{16'd24576, 16'd40960, 16'd65535},
         '{16'd57344, 16'd57344, 16'd65535},
         '{16'hFFFF,  16'hFFFF,  16'hFFFF},
         '{16'hAAAA,  16'h5555,  16'hAAAA},
         '{16'h5555,  16'hAAAA,  16'h5555},
         '{16'd8191,  16'd8193,  16'd1},
         '{16'd1,     16'd65535, 16'd1},
         '{16'd16383, 16'd49153, 16'd32768},
         '{16'd0,     16'd0,     16'd1},
         '{16'd32768, 16'd32768, 16'd2}
      };
      for (int i = 0; i < 20; i++) send_point(pts[i][0], pts[i][1], pts[i][2]);
   endtask

   task automatic test_random_points();
      repeat (RANDOM_POINTS) send_point(pick_angle(), pick_angle(), pick_radius());
   endtask

   // full-rate stream, no idling on either side
   task automatic test_full_rate_stream();
      req_idle_on = 1'b0;
      rsp_stall_on = 1'b0;
      repeat (STREAM_POINTS) send_point(pick_angle(), pick_angle(), pick_radius());
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_points.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_points.size() != 0) begin
         $display("%0t: %0d transactions never returned: expected x=%0d y=%0d z=%0d first",
                  $time, pending_points.size(), pending_points[0].x, pending_points[0].y,
                  pending_points[0].z);
         error_count++;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_points();
      test_random_points();
      test_full_rate_stream();
      drain_results();
      $display("Converted %0d mesh points (%0d with zero radius), %0d results checked,",
               sent_count, zero_radius_count, checked_count);
      $display("angles swept across quadrant and octant seams, radius from zero to full scale");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("%0t: timed out with %0d transactions outstanding", $time, pending_points.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
